### sv/asymmetric_slide_smoother_defines.svh
// ----------------------------------------------------------------------------
// asymmetric slide smoother assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef ASYMMETRIC_SLIDE_SMOOTHER_DEFINES_SVH
`define ASYMMETRIC_SLIDE_SMOOTHER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ASLSM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aslsm assertion failed");

// next-cycle implication, disabled during reset
`define ASLSM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aslsm assertion failed");

`endif

### sv/aslsm_pkg.sv
// ----------------------------------------------------------------------------
// aslsm_pkg
// shared widths, codes and types of the asymmetric slide smoother
// ----------------------------------------------------------------------------
package aslsm_pkg;

	localparam int ValW      = 48;
	localparam int SlideW    = 32;
	localparam int CfgIdxW   = 2;
	localparam int DivW      = 64;
	localparam int DivCntW   = 6;
	localparam int FracShift = 16;
	localparam int SnapShift = 20;
	localparam int TolW      = ValW - SnapShift;

	localparam logic [SlideW-1:0] SLIDE_ONE  = 32'd65536;
	localparam logic [TolW-1:0]   SNAP_FLOOR = 28'd16;

	// request kinds
	localparam logic [1:0] REQ_VALUE = 2'd0;
	localparam logic [1:0] REQ_BANG  = 2'd1;
	localparam logic [1:0] REQ_SET   = 2'd2;
	localparam logic [1:0] REQ_RESET = 2'd3;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_SLIDE_UP   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_SLIDE_DOWN = 2'd1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### sv/asymmetric_slide_smoother.sv
// ----------------------------------------------------------------------------
// asymmetric_slide_smoother
// one-pole slide filter with separate rise and fall amounts
// ----------------------------------------------------------------------------
// Each value or bang word moves the running value toward the staged target by
// (target - running) / slide, with slide_up used while the target is above the
// running value and slide_down otherwise; amounts below 1.0 act as 1.0. Values
// are signed Q24.24, slide amounts unsigned Q16.16. The quotient truncates
// toward zero and the result snaps onto the target once within
// max(2^-20, |target| >> 20). A value or bang word passes from accept to result
// through a setup state, a divider load, 64 divide steps, a state that sees the
// divider finish and a finish state, paced by the bit-serial divider that
// produces one quotient bit per cycle; the input is not ready during that time.
// The finish state lasts for as long as an earlier result still waits unread
// in the output register. Set and reset words are applied as they are accepted
// and produce no result. A finished result sits in the output register while
// the next word is accepted. Registers are written through the cfg port and
// take effect on the next step.
module asymmetric_slide_smoother (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// register write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [aslsm_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [aslsm_pkg::SlideW-1:0]         cfg_data,
	// input words
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           req_type,
	input  logic signed [aslsm_pkg::ValW-1:0]    new_value,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [aslsm_pkg::ValW-1:0]    smoothed_value
);
	import aslsm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_LOAD  = 2'd2;
	localparam logic [1:0] ST_DIV   = 2'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]        state_q;
	logic [SlideW-1:0] slide_up_q;
	logic [SlideW-1:0] slide_down_q;
	logic [ValW-1:0]   run_q;
	logic [ValW-1:0]   stage_q;

	// per-step working registers
	logic [ValW-1:0]   mag_q;
	logic              neg_q;
	logic [SlideW-1:0] seff_q;
	logic [TolW-1:0]   tol_q;

	logic              out_valid_q;
	logic [ValW-1:0]   out_q;

	logic        in_fire;
	logic        fin_go;
	logic        div_start;
	logic [DivW-1:0] quotient;
	div_stat_t   div_stat;

	// setup cycle arithmetic
	logic [ValW:0]     diff;
	logic [ValW:0]     diff_neg;
	logic              rising;
	logic [SlideW-1:0] slide_sel;
	logic [ValW-1:0]   abs_x;
	logic [TolW-1:0]   tol_raw;

	// finish cycle arithmetic
	logic [ValW-1:0] q48;
	logic [ValW:0]   next_sum;
	logic [ValW-1:0] resid;
	logic            snap;
	logic [ValW-1:0] next_val;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == {1'b0, ST_IDLE});
	assign in_fire   = in_valid && in_ready;

	// the finished word may only overwrite the output register once it is free
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign div_start = (state_q == {1'b0, ST_LOAD});

	// direction, magnitude and slide amount for this step
	assign diff      = {stage_q[ValW-1], stage_q} - {run_q[ValW-1], run_q};
	assign diff_neg  = -diff;
	assign rising    = !diff[ValW] && (diff != '0);
	assign slide_sel = rising ? slide_up_q : slide_down_q;
	assign abs_x     = stage_q[ValW-1] ? (-stage_q) : stage_q;
	assign tol_raw   = abs_x[ValW-1:SnapShift];

	// quotient never exceeds the difference magnitude, so 48 bits hold it
	assign q48      = quotient[ValW-1:0];
	assign next_sum = neg_q ? ({run_q[ValW-1], run_q} - {1'b0, q48})
	                        : ({run_q[ValW-1], run_q} + {1'b0, q48});
	assign resid    = mag_q - q48;
	assign snap     = (resid <= {{SnapShift{1'b0}}, tol_q});
	assign next_val = snap ? stage_q : next_sum[ValW-1:0];

	aslsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({mag_q, {FracShift{1'b0}}}),
		.divisor  (seff_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= {1'b0, ST_IDLE};
			slide_up_q   <= SLIDE_ONE;
			slide_down_q <= SLIDE_ONE;
			run_q        <= '0;
			stage_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SLIDE_UP:   slide_up_q   <= cfg_data;
					CFG_SLIDE_DOWN: slide_down_q <= cfg_data;
					default: ;
				endcase
			end

			// a word read out while the next one finishes is replaced, not cleared
			if (out_valid_q && out_ready && !fin_go)
				out_valid_q <= 1'b0;

			unique case (state_q)
				{1'b0, ST_IDLE}: begin
					if (in_fire) begin
						unique case (req_type)
							REQ_VALUE: begin
								stage_q <= new_value;
								state_q <= {1'b0, ST_SETUP};
							end
							REQ_BANG:  state_q <= {1'b0, ST_SETUP};
							REQ_SET:   stage_q <= new_value;
							REQ_RESET: run_q   <= '0;
							default: ;
						endcase
					end
				end
				{1'b0, ST_SETUP}: state_q <= {1'b0, ST_LOAD};
				{1'b0, ST_LOAD}:  state_q <= {1'b0, ST_DIV};
				{1'b0, ST_DIV}: begin
					if (div_stat.done && !div_stat.busy)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						run_q       <= next_val;
						out_valid_q <= 1'b1;
						state_q     <= {1'b0, ST_IDLE};
					end
				end
				default: state_q <= {1'b0, ST_IDLE};
			endcase
		end
	end

	// step operands, captured in the setup cycle
	always_ff @(posedge clk) begin
		if (state_q == {1'b0, ST_SETUP}) begin
			neg_q  <= diff[ValW];
			mag_q  <= diff[ValW] ? diff_neg[ValW-1:0] : diff[ValW-1:0];
			seff_q <= (slide_sel < SLIDE_ONE) ? SLIDE_ONE : slide_sel;
			tol_q  <= (tol_raw < SNAP_FLOOR) ? SNAP_FLOOR : tol_raw;
		end
		if (fin_go)
			out_q <= next_val;
	end

	assign out_valid      = out_valid_q;
	assign smoothed_value = out_q;

endmodule

### sv/aslsm_div.sv
// ----------------------------------------------------------------------------
// aslsm_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aslsm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [aslsm_pkg::DivW-1:0]     dividend,
	input  logic [aslsm_pkg::SlideW-1:0]   divisor,
	output logic [aslsm_pkg::DivW-1:0]     quotient,
	output aslsm_pkg::div_stat_t           stat
);
	import aslsm_pkg::*;

	logic [DivW-1:0]    quo_q;
	logic [SlideW:0]    rem_q;
	logic [SlideW-1:0]  dvs_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [SlideW:0] rem_sh;
	logic [SlideW:0] dvs_ext;
	logic            fits;

	assign rem_sh  = {rem_q[SlideW-1:0], quo_q[DivW-1]};
	assign dvs_ext = {1'b0, dvs_q};
	assign fits    = (rem_sh >= dvs_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {DivCntW{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out the top as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DivW-2:0], fits};
			rem_q <= fits ? (rem_sh - dvs_ext) : rem_sh;
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### sv/aslsm_checker.sv
// ----------------------------------------------------------------------------
// aslsm_checker
// port-level checks of the asymmetric slide smoother, bound to the top level
// ----------------------------------------------------------------------------
`include "asymmetric_slide_smoother_defines.svh"

module aslsm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [1:0]                        req_type,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [aslsm_pkg::ValW-1:0] smoothed_value
);
	import aslsm_pkg::*;

	// a stepping word keeps the block busy
	`ASLSM_ASSERT_NXT(a_step_busy, in_valid && in_ready && (req_type == REQ_VALUE || req_type == REQ_BANG), !in_ready)

	// set and reset words never produce a result
	`ASLSM_ASSERT_NXT(a_quiet_kinds, in_valid && in_ready && (req_type == REQ_SET || req_type == REQ_RESET), !$rose(out_valid))

	// the block is back to idle when a result appears
	`ASLSM_ASSERT_IMP(a_idle_on_result, $rose(out_valid), in_ready)

	// a stalled result holds
	`ASLSM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(smoothed_value))

endmodule

bind asymmetric_slide_smoother aslsm_checker u_aslsm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.req_type       (req_type),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.smoothed_value (smoothed_value)
);
